@@ rtl/rpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpfa_pkg: shared types and codes of the page frame allocator
// Action and status codes, the output record and the queue entry type.
// ----------------------------------------------------------------------------
package rpfa_pkg;

  localparam int ACTION_W    = 3;
  localparam int PAGE_W      = 10;
  localparam int STATUS_W    = 2;
  localparam int RC_W        = 8;
  // page frames managed; matches the PAGE_W-bit page field
  localparam int FRAME_COUNT = 1024;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_SHARE = 3'd2,
    ACT_COW   = 3'd3,
    ACT_INIT  = 3'd4,
    ACT_NOP   = 3'd7
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_UNDER = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [PAGE_W-1:0]   page;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   result_page;
    logic [STATUS_W-1:0] status;
    logic [RC_W-1:0]     ref_count;
    logic                page_released;
    logic                copy_needed;
    logic                make_writable;
  } rsp_t;

endpackage

@@ rtl/rpfa_if.sv @@
// ----------------------------------------------------------------------------
// rpfa_req_if / rpfa_rsp_if / rpfa_cfg_if: valid-ready channels
// Request, result and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface rpfa_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [9:0] page_index;
  modport source (output valid, output action, output page_index, input ready);
  modport sink   (input valid, input action, input page_index, output ready);
endinterface

interface rpfa_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] result_page;
  logic [1:0] status;
  logic [7:0] ref_count;
  logic       page_released;
  logic       copy_needed;
  logic       make_writable;
  modport source (output valid, output result_page, output status, output ref_count,
                  output page_released, output copy_needed, output make_writable,
                  input ready);
  modport sink   (input valid, input result_page, input status, input ref_count,
                  input page_released, input copy_needed, input make_writable,
                  output ready);
endinterface

interface rpfa_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rpfa_front.sv @@
// ----------------------------------------------------------------------------
// rpfa_front: request classifier and queue
// Decode the action, wrap the page and hold requests in a two-entry queue.
// ----------------------------------------------------------------------------
module rpfa_front
  import rpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_action,
  input  logic [PAGE_W-1:0] in_page,
  output logic              q_valid,
  input  logic              q_pop,
  output req_t              q_head
);
  req_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  req_t       cls;
  logic       push;

  always_comb begin
    cls = '0;
    // the page field spans exactly the frame count, so it wraps by width
    cls.page = in_page;
    case (in_action)
      ACT_ALLOC: cls.action = ACT_ALLOC;
      ACT_FREE:  cls.action = ACT_FREE;
      ACT_SHARE: cls.action = ACT_SHARE;
      ACT_COW:   cls.action = ACT_COW;
      ACT_INIT:  cls.action = ACT_INIT;
      default:   cls.action = ACT_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= cls;
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count corrupt");
endmodule

@@ rtl/rpfa_back.sv @@
// ----------------------------------------------------------------------------
// rpfa_back: allocator execution engine
// Word bitmap with summary bits, count memory, first-free search and init sweep.
// ----------------------------------------------------------------------------
module rpfa_back
  import rpfa_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAGE_W-1:0] os_last_page,
  input  logic              q_valid,
  output logic              q_pop,
  input  req_t              q_head,
  output logic              busy,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp
);
  localparam int PW     = $clog2(FRAME_COUNT);
  localparam int NWORDS = (FRAME_COUNT + 31) / 32;
  localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_FIND, S_EXEC, S_WB, S_OUT} state_t;

  logic [31:0]           bmap [NWORDS];
  logic [COUNT_BITS-1:0] refs [FRAME_COUNT];
  logic [NWORDS-1:0]     full_r;

  state_t                state_r;
  req_t                  req_r;
  logic [WW-1:0]         wix_r;
  logic [31:0]           word_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [PW-1:0]         np_r;
  logic                  found_r;
  logic [WW:0]           sweep_r;
  logic                  init_r;
  rsp_t                  rsp_r;
  logic                  vld_r;

  logic [WW-1:0]  first_word;
  logic           any_free;
  logic [4:0]     bitpos;
  logic           bit_ok;

  // write-back decision for the request in S_WB
  rsp_t           wb_rsp;
  logic           wb_take;
  logic           wb_dec;
  logic           wb_inc;
  logic           wb_rel;

  always_comb begin
    first_word = '0;
    any_free   = 1'b0;
    for (int i = NWORDS-1; i >= 0; i--) begin
      if (!full_r[i]) begin
        first_word = WW'(i);
        any_free   = 1'b1;
      end
    end
  end

  always_comb begin
    bitpos = '0;
    bit_ok = 1'b0;
    for (int b = 31; b >= 0; b--) begin
      if (!word_r[b] && ((32'(wix_r) * 32 + 32'(b)) < 32'(FRAME_COUNT))) begin
        bitpos = 5'(b);
        bit_ok = 1'b1;
      end
    end
  end

  always_comb begin
    wb_rsp  = '0;
    wb_take = 1'b0;
    wb_dec  = 1'b0;
    wb_inc  = 1'b0;
    wb_rel  = 1'b0;
    case (req_r.action)
      ACT_ALLOC: begin
        if (found_r) begin
          wb_take               = 1'b1;
          wb_rsp.result_page    = PAGE_W'(np_r);
          wb_rsp.ref_count      = RC_W'(1);
        end else begin
          wb_rsp.status = ST_NOMEM;
        end
      end
      ACT_COW: begin
        if (cnt_r > COUNT_BITS'(1)) begin
          if (found_r) begin
            wb_take            = 1'b1;
            wb_dec             = 1'b1;
            wb_rsp.result_page = PAGE_W'(np_r);
            wb_rsp.copy_needed = 1'b1;
            wb_rsp.ref_count   = RC_W'(cnt_r - 1'b1);
          end else begin
            wb_rsp.status    = ST_NOMEM;
            wb_rsp.ref_count = RC_W'(cnt_r);
          end
        end else if (cnt_r == COUNT_BITS'(1)) begin
          wb_rsp.result_page   = PAGE_W'(req_r.page);
          wb_rsp.make_writable = 1'b1;
          wb_rsp.ref_count     = RC_W'(1);
        end else begin
          wb_rsp.result_page = PAGE_W'(req_r.page);
          wb_rsp.status      = ST_UNDER;
        end
      end
      ACT_FREE: begin
        wb_rsp.result_page = PAGE_W'(req_r.page);
        if (cnt_r == '0) begin
          wb_rsp.status = ST_UNDER;
        end else begin
          wb_dec           = 1'b1;
          wb_rsp.ref_count = RC_W'(cnt_r - 1'b1);
          if (cnt_r == COUNT_BITS'(1)) begin
            wb_rsp.page_released = 1'b1;
            wb_rel               = 1'b1;
          end
        end
      end
      ACT_SHARE: begin
        wb_rsp.result_page = PAGE_W'(req_r.page);
        if (cnt_r == CMAX) begin
          wb_rsp.status    = ST_SAT;
          wb_rsp.ref_count = RC_W'(cnt_r);
        end else begin
          wb_inc           = 1'b1;
          wb_rsp.ref_count = RC_W'(cnt_r + 1'b1);
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign rsp_valid  = vld_r;
  assign rsp        = rsp_r;

  function automatic logic [31:0] init_word(input logic [WW:0] w,
                                            input logic [PAGE_W-1:0] last);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < 32; b++)
      r[b] = ((32'(w) * 32 + 32'(b)) <= 32'(last)) &&
             ((32'(w) * 32 + 32'(b)) < 32'(FRAME_COUNT));
    return r;
  endfunction

  // count clear walks the count memory one entry per cycle
  logic [PW:0] cclr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sweep_r <= '0;
      cclr_r  <= '0;
      init_r  <= 1'b0;
      vld_r   <= 1'b0;
      full_r  <= '0;
    end else begin
      if (vld_r && rsp_ready) vld_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (cclr_r < (PW+1)'(FRAME_COUNT)) begin
            refs[cclr_r[PW-1:0]] <= '0;
            cclr_r <= cclr_r + 1'b1;
          end
          if (sweep_r < (WW+1)'(NWORDS)) begin
            bmap[sweep_r[WW-1:0]] <= init_r ? init_word(sweep_r, os_last_page) : '0;
            full_r[sweep_r[WW-1:0]] <= init_r ?
              (init_word(sweep_r, os_last_page) == init_word(sweep_r, '1)) : 1'b0;
            sweep_r <= sweep_r + 1'b1;
          end
          if (cclr_r >= (PW+1)'(FRAME_COUNT) && sweep_r >= (WW+1)'(NWORDS)) begin
            if (init_r) begin
              rsp_r <= '0;
              vld_r <= 1'b1;
              state_r <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
            init_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_head;
            if (q_head.action == ACT_INIT) begin
              init_r  <= 1'b1;
              sweep_r <= '0;
              cclr_r  <= '0;
              state_r <= S_CLEAR;
            end else if (q_head.action == ACT_NOP) begin
              rsp_r   <= '0;
              vld_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          cnt_r   <= refs[req_r.page[PW-1:0]];
          wix_r   <= first_word;
          found_r <= any_free;
          state_r <= S_FIND;
        end
        S_FIND: begin
          word_r  <= bmap[wix_r];
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          np_r <= PW'(32'(wix_r) * 32 + 32'(bitpos));
          found_r <= found_r && bit_ok;
          state_r <= S_WB;
        end
        S_WB: begin
          rsp_r   <= wb_rsp;
          vld_r   <= 1'b1;
          state_r <= S_OUT;
          if (wb_take) begin
            bmap[wix_r]   <= word_r | (32'd1 << bitpos);
            full_r[wix_r] <= &(word_r | (32'd1 << bitpos));
            // the old page's decrement wins when the new page is the same one
            if (!wb_dec || np_r != req_r.page[PW-1:0]) refs[np_r] <= COUNT_BITS'(1);
          end
          if (wb_dec || wb_inc)
            refs[req_r.page[PW-1:0]] <= wb_inc ? cnt_r + 1'b1 : cnt_r - 1'b1;
          if (wb_rel) begin
            wix_r   <= req_r.page[PW-1:5];
            found_r <= 1'b1;
          end
        end
        S_OUT: begin
          // a release still has to clear its bitmap bit
          if (rsp_r.page_released && found_r) begin
            bmap[wix_r] <= bmap[wix_r] & ~(32'd1 << req_r.page[4:0]);
            full_r[wix_r] <= 1'b0;
            found_r <= 1'b0;
          end else if (!vld_r || rsp_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_rsp_in_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !rsp_ready) |=> vld_r) else $error("result dropped");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop while busy");
  a_idle_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !vld_r) else $error("stale result in idle");
endmodule

@@ rtl/refcounted_page_frame_allocator_top.sv @@
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_top: page frame allocator with ref counts
// Front queue plus execution engine with word bitmap and count memory.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* carries one request (action, page_index) per valid/ready handshake.
//  - out_* returns exactly one result per request, in order.
//  - cfg_* writes os_last_page; write it only while the block is idle.
//  - Steps for alloc/free/share/copy-on-write, once the request is accepted:
//    pop, read count and pick a free word from the summary bits, read word,
//    priority-encode, write back; out valid is registered at the write-back.
//    Init clears the count memory one entry per cycle, and its result comes
//    once the clear is done.
//  - One request at a time in the engine; a free that releases its page also
//    clears its bitmap bit before the engine returns to idle.
//  - Reset: clears both stores in one pass; the two-entry front
//    queue takes up to two requests meanwhile, then drops in_ready.
//  - Receiver stall: the result holds in the output register; the engine
//    waits, and the queue fills and then drops in_ready.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_top
  import rpfa_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rpfa_req_if.sink   in_ch,
  rpfa_rsp_if.source out_ch,
  rpfa_cfg_if.sink   cfg_ch
);
  logic [PAGE_W-1:0] os_last_r;
  logic              q_valid, q_pop, busy;
  req_t              q_head;
  rsp_t              rsp;

  // hold config register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      os_last_r <= '0;
    end else if (cfg_ch.valid) begin
      os_last_r <= cfg_ch.data;
    end
  end

  rpfa_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.action), .in_page(in_ch.page_index),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  rpfa_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .os_last_page(os_last_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head), .busy(busy),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp(rsp)
  );

  assign out_ch.result_page   = rsp.result_page;
  assign out_ch.status        = rsp.status;
  assign out_ch.ref_count     = rsp.ref_count;
  assign out_ch.page_released = rsp.page_released;
  assign out_ch.copy_needed   = rsp.copy_needed;
  assign out_ch.make_writable = rsp.make_writable;

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.result_page))
    else $error("result changed under stall");
  a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> busy) else $error("result outside a request");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.ready) else $error("config stalled");
endmodule
